FILE: src/json_string_unescape_utf8_assert.svh
// ----------------------------------------------------------------------------
// JSON string unescape assertion macros
// Shared concurrent assertion shorthands for the unescape block.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// same-cycle implication, disabled during reset
`define JSU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define JSU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/jsu_pkg.sv
// ----------------------------------------------------------------------------
// JSON string unescape package
// Types, character codes and helper functions for the unescape block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jsu_pkg;

  // character codes
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // decoded byte values for the simple escapes
  localparam logic [7:0] BS_CODE  = 8'h08;
  localparam logic [7:0] FF_CODE  = 8'h0C;
  localparam logic [7:0] LF_CODE  = 8'h0A;
  localparam logic [7:0] CR_CODE  = 8'h0D;
  localparam logic [7:0] TAB_CODE = 8'h09;

  // surrogate ranges
  localparam logic [15:0] HI_SUR_LO = 16'hD800;
  localparam logic [15:0] HI_SUR_HI = 16'hDBFF;
  localparam logic [15:0] LO_SUR_LO = 16'hDC00;
  localparam logic [15:0] LO_SUR_HI = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // replacement character U+FFFD in UTF-8
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;
  localparam logic [2:0] REPL_LEN = 3'd3;

  // decoder state, one-hot
  typedef enum logic [5:0] {
    MODE_PLAIN   = 6'b000001,
    MODE_ESC     = 6'b000010,
    MODE_HEX1    = 6'b000100,
    MODE_WAIT_BS = 6'b001000,
    MODE_WAIT_U  = 6'b010000,
    MODE_HEX2    = 6'b100000
  } mode_e;

  // status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_UNTERM_ESC = 3'd1,
    ST_SHORT_HEX  = 3'd2,
    ST_BAD_HEX    = 3'd3,
    ST_BAD_ESC    = 3'd4,
    ST_CTRL_CHAR  = 3'd5,
    ST_UNTERM_STR = 3'd6
  } status_e;

  // UTF-8 encoding of one code point
  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] bytes;
  } utf8_t;

  // word list produced by one input byte
  typedef struct packed {
    logic            fffd;
    logic [2:0]      main_n;
    logic [3:0][7:0] main_b;
    logic            rep;
    logic            rep_done;
    status_e         rep_status;
    logic [2:0]      total;
  } wlist_t;

  // hex digit value with a valid flag in the top bit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'h00;
      if (c inside {[8'h30:8'h39]}) begin
        t = c - 8'h30;
        hex_val = {1'b1, t[3:0]};
      end else if (c inside {[8'h61:8'h66]}) begin
        t = c - 8'h57;
        hex_val = {1'b1, t[3:0]};
      end else if (c inside {[8'h41:8'h46]}) begin
        t = c - 8'h37;
        hex_val = {1'b1, t[3:0]};
      end else begin
        hex_val = 5'd0;
      end
    end
  endfunction

  // code point to UTF-8 bytes, first byte at index 0
  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t r;
    begin
      r.bytes = '0;
      if (cp < 21'h80) begin
        r.len      = 3'd1;
        r.bytes[0] = cp[7:0];
      end else if (cp < 21'h800) begin
        r.len      = 3'd2;
        r.bytes[0] = {3'b110, cp[10:6]};
        r.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
        r.len      = 3'd3;
        r.bytes[0] = {4'b1110, cp[15:12]};
        r.bytes[1] = {2'b10, cp[11:6]};
        r.bytes[2] = {2'b10, cp[5:0]};
      end else begin
        r.len      = 3'd4;
        r.bytes[0] = {5'b11110, cp[20:18]};
        r.bytes[1] = {2'b10, cp[17:12]};
        r.bytes[2] = {2'b10, cp[11:6]};
        r.bytes[3] = {2'b10, cp[5:0]};
      end
      utf8_enc = r;
    end
  endfunction

endpackage

FILE: src/json_string_unescape_utf8.sv
// One input byte of a JSON string body (after the opening quote) is taken per cycle while
// in_stall_o is low and turned into the decoded UTF-8 output words it causes, plus one
// status word for the closing quote, end of input or an error. A byte that causes at most
// one output word sustains one byte per cycle while res_stall_i is low; a byte that causes
// n words (up to 6, e.g. a replacement character followed by a 3-byte character) holds the
// input until all n words are drained, since the output port drains the registered word
// list one word per cycle when not stalled. Bytes that cause no word (a backslash, hex
// digits) do not hold the input. Each byte passes the input and word-list registers.
// ----------------------------------------------------------------------------
// JSON string unescape to UTF-8
// Input register, single-pass decode into a registered word list, word drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "json_string_unescape_utf8_assert.svh"

module json_string_unescape_utf8 (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  input  logic [7:0] in_byte_i,
  output logic       res_valid_o,
  input  logic       res_stall_i,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       string_done_o,
  output logic [2:0] status_o,
  output logic       last_o
);

  // input register
  logic       in_valid_q;
  logic       kind_q;
  logic [7:0] byte_q;

  // decoder state
  jsu_pkg::mode_e mode_q, mode_d;
  logic [15:0]    hex_acc_q, hex_acc_d;
  logic [2:0]     hex_cnt_q, hex_cnt_d;
  logic           hex_bad_q, hex_bad_d;
  logic [9:0]     high_q, high_d;

  // word list register
  logic             list_valid_q;
  jsu_pkg::wlist_t  list_q, list_d;
  logic [2:0]       idx_q;

  // handshake
  logic in_accept, out_take, list_last, list_free, s1_move;

  // decode intermediates
  logic [4:0]       dig;
  logic [15:0]      acc_n;
  logic             bad_n;
  logic [2:0]       cnt_n;
  logic             full_n;
  logic             do_plain, do_esc, do_fin;
  logic             fffd, emit, raw, rep, rep_done;
  jsu_pkg::status_e rep_st;
  logic [20:0]      cp;
  jsu_pkg::utf8_t   enc;

  // output select
  logic [2:0] fffd_n;
  logic [2:0] jdx;

  assign out_take   = list_valid_q && !res_stall_i;
  assign list_last  = idx_q == (list_q.total - 3'd1);
  assign list_free  = !list_valid_q || (out_take && list_last);
  assign s1_move    = in_valid_q && list_free;
  assign in_stall_o = in_valid_q && !list_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  // hex digit collection
  always_comb begin
    dig    = jsu_pkg::hex_val(byte_q);
    acc_n  = dig[4] ? {hex_acc_q[11:0], dig[3:0]} : hex_acc_q;
    bad_n  = hex_bad_q | ~dig[4];
    cnt_n  = hex_cnt_q + 3'd1;
    full_n = cnt_n >= 3'd4;
  end

  // decode one byte into state update and word list
  always_comb begin
    mode_d    = mode_q;
    hex_acc_d = hex_acc_q;
    hex_cnt_d = hex_cnt_q;
    hex_bad_d = hex_bad_q;
    high_d    = high_q;
    do_plain  = 1'b0;
    do_esc    = 1'b0;
    do_fin    = 1'b0;
    fffd      = 1'b0;
    emit      = 1'b0;
    raw       = 1'b0;
    cp        = '0;
    rep       = 1'b0;
    rep_done  = 1'b0;
    rep_st    = jsu_pkg::ST_OK;

    if (kind_q) begin
      // end of input
      rep    = 1'b1;
      mode_d = jsu_pkg::MODE_PLAIN;
      case (mode_q)
        jsu_pkg::MODE_ESC:     rep_st = jsu_pkg::ST_UNTERM_ESC;
        jsu_pkg::MODE_HEX1:    rep_st = jsu_pkg::ST_SHORT_HEX;
        jsu_pkg::MODE_WAIT_BS: begin
          fffd   = 1'b1;
          rep_st = jsu_pkg::ST_UNTERM_STR;
        end
        jsu_pkg::MODE_WAIT_U: begin
          fffd   = 1'b1;
          rep_st = jsu_pkg::ST_UNTERM_ESC;
        end
        jsu_pkg::MODE_HEX2: begin
          fffd   = 1'b1;
          rep_st = jsu_pkg::ST_SHORT_HEX;
        end
        default:               rep_st = jsu_pkg::ST_UNTERM_STR;
      endcase
    end else begin
      case (mode_q)
        jsu_pkg::MODE_ESC: do_esc = 1'b1;
        jsu_pkg::MODE_HEX1: begin
          hex_acc_d = acc_n;
          hex_bad_d = bad_n;
          hex_cnt_d = cnt_n;
          do_fin    = full_n;
        end
        jsu_pkg::MODE_WAIT_BS: begin
          if (byte_q == jsu_pkg::CH_BSL) begin
            mode_d = jsu_pkg::MODE_WAIT_U;
          end else begin
            fffd     = 1'b1;
            do_plain = 1'b1;
          end
        end
        jsu_pkg::MODE_WAIT_U: begin
          if (byte_q == jsu_pkg::CH_U) begin
            mode_d    = jsu_pkg::MODE_HEX2;
            hex_acc_d = '0;
            hex_cnt_d = '0;
            hex_bad_d = 1'b0;
          end else begin
            fffd   = 1'b1;
            do_esc = 1'b1;
          end
        end
        jsu_pkg::MODE_HEX2: begin
          hex_acc_d = acc_n;
          hex_bad_d = bad_n;
          hex_cnt_d = cnt_n;
          if (full_n) begin
            if (!bad_n && acc_n >= jsu_pkg::LO_SUR_LO && acc_n <= jsu_pkg::LO_SUR_HI) begin
              emit   = 1'b1;
              cp     = jsu_pkg::SUPP_BASE + {1'b0, high_q, acc_n[9:0]};
              mode_d = jsu_pkg::MODE_PLAIN;
            end else begin
              fffd   = 1'b1;
              do_fin = 1'b1;
            end
          end
        end
        default: do_plain = 1'b1;
      endcase
    end

    // plain character, passed through as the raw byte; quote, backslash and control bytes handled
    if (do_plain) begin
      mode_d = jsu_pkg::MODE_PLAIN;
      if (byte_q == jsu_pkg::CH_QUOTE) begin
        rep      = 1'b1;
        rep_done = 1'b1;
      end else if (byte_q == jsu_pkg::CH_BSL) begin
        mode_d = jsu_pkg::MODE_ESC;
      end else if (byte_q < jsu_pkg::CH_SPACE) begin
        rep    = 1'b1;
        rep_st = jsu_pkg::ST_CTRL_CHAR;
      end else begin
        raw = 1'b1;
      end
    end

    // escape letter
    if (do_esc) begin
      mode_d = jsu_pkg::MODE_PLAIN;
      emit   = 1'b1;
      case (byte_q)
        jsu_pkg::CH_QUOTE: cp = {13'd0, jsu_pkg::CH_QUOTE};
        jsu_pkg::CH_BSL:   cp = {13'd0, jsu_pkg::CH_BSL};
        jsu_pkg::CH_SLASH: cp = {13'd0, jsu_pkg::CH_SLASH};
        jsu_pkg::CH_B:     cp = {13'd0, jsu_pkg::BS_CODE};
        jsu_pkg::CH_F:     cp = {13'd0, jsu_pkg::FF_CODE};
        jsu_pkg::CH_N:     cp = {13'd0, jsu_pkg::LF_CODE};
        jsu_pkg::CH_R:     cp = {13'd0, jsu_pkg::CR_CODE};
        jsu_pkg::CH_T:     cp = {13'd0, jsu_pkg::TAB_CODE};
        jsu_pkg::CH_U: begin
          emit      = 1'b0;
          mode_d    = jsu_pkg::MODE_HEX1;
          hex_acc_d = '0;
          hex_cnt_d = '0;
          hex_bad_d = 1'b0;
        end
        default: begin
          emit   = 1'b0;
          rep    = 1'b1;
          rep_st = jsu_pkg::ST_BAD_ESC;
        end
      endcase
    end

    // four digits of a first escape, or of a second escape that is no low surrogate, collected
    if (do_fin) begin
      mode_d = jsu_pkg::MODE_PLAIN;
      if (bad_n) begin
        rep    = 1'b1;
        rep_st = jsu_pkg::ST_BAD_HEX;
      end else if (acc_n >= jsu_pkg::HI_SUR_LO && acc_n <= jsu_pkg::HI_SUR_HI) begin
        high_d = acc_n[9:0];
        mode_d = jsu_pkg::MODE_WAIT_BS;
      end else begin
        emit = 1'b1;
        cp   = {5'd0, acc_n};
      end
    end
  end

  // assemble word list
  always_comb begin
    enc                = jsu_pkg::utf8_enc(cp);
    list_d.fffd        = fffd;
    list_d.main_n      = raw ? 3'd1 : (emit ? enc.len : 3'd0);
    list_d.main_b      = raw ? {24'd0, byte_q} : enc.bytes;
    list_d.rep         = rep;
    list_d.rep_done    = rep_done;
    list_d.rep_status  = rep_st;
    list_d.total       = (fffd ? jsu_pkg::REPL_LEN : 3'd0) + list_d.main_n + {2'd0, rep};
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (s1_move) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q <= kind_i;
      byte_q <= in_byte_i;
    end
  end

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= jsu_pkg::MODE_PLAIN;
      hex_acc_q <= '0;
      hex_cnt_q <= '0;
      hex_bad_q <= 1'b0;
      high_q    <= '0;
    end else if (s1_move) begin
      mode_q    <= mode_d;
      hex_acc_q <= hex_acc_d;
      hex_cnt_q <= hex_cnt_d;
      hex_bad_q <= hex_bad_d;
      high_q    <= high_d;
    end
  end

  // word list and drain index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_valid_q <= 1'b0;
      idx_q        <= '0;
    end else if (s1_move) begin
      list_valid_q <= list_d.total != 3'd0;
      idx_q        <= '0;
    end else if (out_take && list_last) begin
      list_valid_q <= 1'b0;
      idx_q        <= '0;
    end else if (out_take) begin
      idx_q <= idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      list_q <= list_d;
    end
  end

  // output word select
  assign fffd_n = list_q.fffd ? jsu_pkg::REPL_LEN : 3'd0;
  assign jdx    = idx_q - fffd_n;

  always_comb begin
    out_valid_o   = 1'b0;
    out_byte_o    = 8'h00;
    string_done_o = 1'b0;
    status_o      = jsu_pkg::ST_OK;
    if (idx_q < fffd_n) begin
      out_valid_o = 1'b1;
      case (idx_q[1:0])
        2'd0:    out_byte_o = jsu_pkg::REPL_B0;
        2'd1:    out_byte_o = jsu_pkg::REPL_B1;
        default: out_byte_o = jsu_pkg::REPL_B2;
      endcase
    end else if (jdx < list_q.main_n) begin
      out_valid_o = 1'b1;
      out_byte_o  = list_q.main_b[jdx[1:0]];
    end else begin
      string_done_o = list_q.rep_done;
      status_o      = list_q.rep_status;
    end
  end

  assign res_valid_o = list_valid_q;
  assign last_o      = list_last;

  // assertions
  `JSU_ASSERT_IMP(a_list_nonempty, clk_i, rst_ni, list_valid_q,
    (list_q.total != 3'd0) && (idx_q < list_q.total), "word list empty or index past end")
  `JSU_ASSERT_NXT(a_idx_step, clk_i, rst_ni, out_take && !list_last,
    list_valid_q && (idx_q == $past(idx_q) + 3'd1), "drain index did not advance")
  `JSU_ASSERT_IMP(a_stall_held, clk_i, rst_ni, in_stall_o,
    in_valid_q && list_valid_q, "input stalled without a held byte and busy list")
  `JSU_ASSERT_IMP(a_done_alone, clk_i, rst_ni, list_valid_q && list_q.rep_done,
    list_q.main_n == 3'd0, "closing quote word mixed with character words")

endmodule
